[design/lem_pkg.sv]
// ----------------------------------------------------------------------------
// lem_pkg
// Shared widths, constants, item types and the log2 fraction table function
// for the log energy meter.
// ----------------------------------------------------------------------------
package lem_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GROUP_W  = 10;
    localparam int SUM_W    = 41;
    localparam int LEVEL_W  = 16;
    localparam int SLOT_W   = 9;

    localparam logic [GROUP_W-1:0] GROUP_RESET = 10'd40;

    // mean carries this many fraction bits before the log
    localparam int MEAN_FRAC = 10;
    // mantissa bits kept below the leading one
    localparam int MANT_BITS = 30;
    localparam int Q16       = 16;

    // long divider: quotient bits resolved per pipeline stage
    localparam int DIV_STEPS  = 6;
    localparam int DIV_STAGES = (SUM_W + MEAN_FRAC + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_W      = DIV_STAGES * DIV_STEPS;
    localparam int POS_W      = $clog2(DIV_W);

    // table entries run up to 1.0 in Q16 inclusive
    localparam int FRAC_W = Q16 + 1;

    // level = floor((5*L - 31*2^16) / 124), L = log2(mean) - MEAN_FRAC in Q16
    localparam int LOG_SCALE = 31;
    localparam int NUM_W     = 26;
    localparam int HI_W      = NUM_W - Q16;
    localparam int HI_OFFSET = 5 * MEAN_FRAC + LOG_SCALE;
    localparam int SAT_NUM   = 124 * (1 << Q16);

    // num/124 = (num>>2)/31, the /31 by reciprocal multiply
    localparam int X_W         = 21;
    localparam int RECIP_W     = 23;
    localparam int DIV31_SHIFT = 27;
    localparam logic [RECIP_W-1:0] DIV31_MUL = 23'd4329605;
    localparam int PROD_W      = X_W + RECIP_W;

    localparam int RING_DEPTH_DEF     = 512;
    localparam int LOG_TABLE_BITS_DEF = 6;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [SLOT_W-1:0] slot;
    } t_sum_item;

    typedef struct packed {
        logic [DIV_W-1:0]  quot;
        logic [SLOT_W-1:0] slot;
    } t_div_item;

    typedef struct packed {
        logic              pos;
        logic              sat;
        logic [PROD_W-1:0] prod;
        logic [SLOT_W-1:0] slot;
    } t_lvl_item;

    // log2(1 + idx/2^tb) in Q16 by repeated squaring of a Q30 value
    function automatic logic [FRAC_W-1:0] log_entry(input int unsigned idx,
                                                    input int unsigned tb);
        logic [63:0]       y;
        logic [FRAC_W-1:0] res;
        int                b;
        res = '0;
        if (idx >= (32'd1 << tb)) begin
            res = FRAC_W'(1 << Q16);
        end else begin
            y = (64'd1 << MANT_BITS) + (64'(idx) << (MANT_BITS - tb));
            for (b = 0; b < Q16; b++) begin
                y   = (y * y) >> MANT_BITS;
                res = {res[FRAC_W-2:0], 1'b0};
                if (y >= (64'd2 << MANT_BITS)) begin
                    res[0] = 1'b1;
                    y      = y >> 1;
                end
            end
        end
        return res;
    endfunction

endpackage

[design/lem_div.sv]
// ----------------------------------------------------------------------------
// lem_div
// Pipelined restoring divider: (sum << MEAN_FRAC) / divisor, a few quotient
// bits per stage, with a valid bit and stall chain per stage.
// ----------------------------------------------------------------------------
module lem_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  lem_pkg::t_sum_item            i_item,
    input  logic [lem_pkg::GROUP_W-1:0]   i_divisor,
    output logic                          o_valid,
    input  logic                          i_ready,
    output lem_pkg::t_div_item            o_item
);

    localparam int NS = lem_pkg::DIV_STAGES;
    localparam int GW = lem_pkg::GROUP_W;
    localparam int DW = lem_pkg::DIV_W;

    logic                      r_vld  [NS];
    logic [GW-1:0]             r_rem  [NS];
    logic [DW-1:0]             r_word [NS];
    logic [lem_pkg::SLOT_W-1:0] r_slot [NS];
    logic [GW-1:0]             n_rem  [NS];
    logic [DW-1:0]             n_word [NS];
    logic [NS-1:0]             w_ld;

    // a stage loads when it is empty or its successor loads
    always_comb begin
        w_ld[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    // remainder and word shift left together; quotient bits enter at the bottom
    always_comb begin
        logic [GW:0]   v_part;
        logic [GW-1:0] v_rem;
        logic [DW-1:0] v_word;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                v_rem  = '0;
                v_word = DW'({i_item.sum, {lem_pkg::MEAN_FRAC{1'b0}}});
            end else begin
                v_rem  = r_rem[k-1];
                v_word = r_word[k-1];
            end
            for (int s = 0; s < lem_pkg::DIV_STEPS; s++) begin
                v_part = {v_rem, v_word[DW-1]};
                v_word = {v_word[DW-2:0], 1'b0};
                if (v_part >= {1'b0, i_divisor}) begin
                    v_rem     = GW'(v_part - {1'b0, i_divisor});
                    v_word[0] = 1'b1;
                end else begin
                    v_rem = v_part[GW-1:0];
                end
            end
            n_rem[k]  = v_rem;
            n_word[k] = v_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_rem[0]  <= n_rem[0];
            r_word[0] <= n_word[0];
            r_slot[0] <= i_item.slot;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_ld[k]) begin
                r_rem[k]  <= n_rem[k];
                r_word[k] <= n_word[k];
                r_slot[k] <= r_slot[k-1];
            end
        end
    end

    assign o_ready     = w_ld[0];
    assign o_valid     = r_vld[NS-1];
    assign o_item.quot = r_word[NS-1];
    assign o_item.slot = r_slot[NS-1];

endmodule

[design/lem_log.sv]
// ----------------------------------------------------------------------------
// lem_log
// Mean to level: leading-one search, table log2 with linear interpolation,
// noise floor offset and scale, ending in the reciprocal multiply for /31.
// ----------------------------------------------------------------------------
module lem_log #(
    parameter int LOG_TABLE_BITS = lem_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  lem_pkg::t_div_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output lem_pkg::t_lvl_item o_item
);

    localparam int NST   = 5;
    localparam int DW    = lem_pkg::DIV_W;
    localparam int PW    = lem_pkg::POS_W;
    localparam int FW    = lem_pkg::FRAC_W;
    localparam int SW    = lem_pkg::SLOT_W;
    localparam int RW    = lem_pkg::MANT_BITS - LOG_TABLE_BITS;
    localparam int TAB_N = 1 << LOG_TABLE_BITS;
    localparam int MW    = FW + RW;

    logic [FW-1:0] w_tab [TAB_N+1];

    for (genvar gi = 0; gi <= TAB_N; gi++) begin : g_tab
        assign w_tab[gi] = lem_pkg::log_entry(gi, LOG_TABLE_BITS);
    end

    logic          r_vld [NST];
    logic [NST-1:0] w_ld;

    always_comb begin
        w_ld[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage A: leading-one position
    logic [PW-1:0] w_a_pos;
    logic [DW-1:0] r_a_q;
    logic [PW-1:0] r_a_pos;
    logic          r_a_zero;
    logic [SW-1:0] r_a_slot;

    always_comb begin
        w_a_pos = '0;
        for (int b = 0; b < DW; b++) begin
            if (i_item.quot[b]) begin
                w_a_pos = PW'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_a_q    <= i_item.quot;
            r_a_pos  <= w_a_pos;
            r_a_zero <= (i_item.quot == '0);
            r_a_slot <= i_item.slot;
        end
    end

    // stage B: normalize, split mantissa, read both table neighbors
    logic [DW-1:0]              w_b_norm;
    logic [lem_pkg::MANT_BITS-1:0] w_b_mant;
    logic [LOG_TABLE_BITS:0]    w_b_idx;
    logic [FW-1:0]              w_b_e0;
    logic [FW-1:0]              w_b_e1;
    logic [PW-1:0]              r_b_pos;
    logic                       r_b_zero;
    logic [FW-1:0]              r_b_e0;
    logic [FW-1:0]              r_b_d;
    logic [RW-1:0]              r_b_r;
    logic [SW-1:0]              r_b_slot;

    always_comb begin
        w_b_norm = r_a_q << (PW'(DW - 1) - r_a_pos);
        w_b_mant = w_b_norm[DW-2 -: lem_pkg::MANT_BITS];
        w_b_idx  = {1'b0, w_b_mant[lem_pkg::MANT_BITS-1 -: LOG_TABLE_BITS]};
        w_b_e0   = w_tab[w_b_idx];
        w_b_e1   = w_tab[w_b_idx + 1'b1];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_b_pos  <= r_a_pos;
            r_b_zero <= r_a_zero;
            r_b_e0   <= w_b_e0;
            r_b_d    <= w_b_e1 - w_b_e0;
            r_b_r    <= w_b_mant[RW-1:0];
            r_b_slot <= r_a_slot;
        end
    end

    // stage C: interpolate the fraction
    logic [MW-1:0] w_c_mul;
    logic [FW-1:0] r_c_frac;
    logic [PW-1:0] r_c_pos;
    logic          r_c_zero;
    logic [SW-1:0] r_c_slot;

    assign w_c_mul = MW'(r_b_d) * MW'(r_b_r);

    always_ff @(posedge i_clk) begin
        if (w_ld[2]) begin
            r_c_frac <= r_b_e0 + FW'(w_c_mul >> RW);
            r_c_pos  <= r_b_pos;
            r_c_zero <= r_b_zero;
            r_c_slot <= r_b_slot;
        end
    end

    // stage D: 5*L - 31*2^16, sign and saturation
    localparam int F5_W = lem_pkg::NUM_W - 4;
    logic [lem_pkg::HI_W-1:0]  w_d_hi;
    logic [F5_W-1:0]           w_d_f5;
    logic signed [lem_pkg::NUM_W-1:0] w_d_num;
    logic                      r_d_pos;
    logic                      r_d_sat;
    logic [lem_pkg::X_W-1:0]   r_d_x;
    logic [SW-1:0]             r_d_slot;

    always_comb begin
        w_d_hi  = lem_pkg::HI_W'({{(lem_pkg::HI_W - PW){1'b0}}, r_c_pos} * 3'd5)
                  - lem_pkg::HI_W'(lem_pkg::HI_OFFSET);
        w_d_f5  = F5_W'(r_c_frac) * F5_W'(5);
        w_d_num = $signed({w_d_hi, {lem_pkg::Q16{1'b0}}})
                  + $signed({4'd0, w_d_f5});
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[3]) begin
            r_d_pos  <= !r_c_zero && (w_d_num > 0);
            r_d_sat  <= (w_d_num >= lem_pkg::NUM_W'(lem_pkg::SAT_NUM));
            r_d_x    <= w_d_num[lem_pkg::X_W+1:2];
            r_d_slot <= r_c_slot;
        end
    end

    // stage E: reciprocal multiply for the /31
    logic                        r_e_pos;
    logic                        r_e_sat;
    logic [lem_pkg::PROD_W-1:0]  r_e_prod;
    logic [SW-1:0]               r_e_slot;

    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            r_e_pos  <= r_d_pos;
            r_e_sat  <= r_d_sat;
            r_e_prod <= lem_pkg::PROD_W'(r_d_x) * lem_pkg::PROD_W'(lem_pkg::DIV31_MUL);
            r_e_slot <= r_d_slot;
        end
    end

    assign o_ready     = w_ld[0];
    assign o_valid     = r_vld[NST-1];
    assign o_item.pos  = r_e_pos;
    assign o_item.sat  = r_e_sat;
    assign o_item.prod = r_e_prod;
    assign o_item.slot = r_e_slot;

endmodule

[design/log_energy_meter.sv]
// ----------------------------------------------------------------------------
// log_energy_meter
// Sums squared audio samples per group and emits a log-scaled energy level
// with its ring slot.
// ----------------------------------------------------------------------------
// The meter takes one sample per clock for as long as results are drained:
// each sample is squared and added into the group sum in the cycle it is
// accepted. When a group closes, its sum is registered and enters a 9-stage
// long divider (6 quotient bits per stage) followed by 5 log and scaling
// stages and the output register. Stages advance independently, so bubbles
// collapse and input is still accepted while a finished level waits at the
// output. A group size of zero counts as one. Configuration writes must land
// while nothing is in flight.
module log_energy_meter #(
    parameter int RING_DEPTH     = lem_pkg::RING_DEPTH_DEF,
    parameter int LOG_TABLE_BITS = lem_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lem_pkg::GROUP_W-1:0]         i_cfg_data,
    input  logic                                i_sample_valid,
    output logic                                o_sample_ready,
    input  logic signed [lem_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_level_valid,
    input  logic                                i_level_ready,
    output logic [lem_pkg::LEVEL_W-1:0]         o_level,
    output logic [lem_pkg::SLOT_W-1:0]          o_slot
);

    localparam int GW = lem_pkg::GROUP_W;
    localparam int SW = lem_pkg::SLOT_W;

    logic [GW-1:0]             r_group_size;
    logic [GW-1:0]             w_group_eff;
    logic [lem_pkg::SUM_W-1:0] r_square_sum;
    logic [GW-1:0]             r_sample_count;
    logic [SW-1:0]             r_ring_pos;

    logic                      w_accept;
    logic signed [2*lem_pkg::SAMPLE_W-1:0] w_square;
    logic [lem_pkg::SUM_W-1:0] n_square_sum;
    logic [GW-1:0]             n_sample_count;
    logic                      w_group_done;
    logic [SW:0]               w_ring_inc;
    logic [SW-1:0]             n_ring_pos;

    logic                      r_s0_valid;
    lem_pkg::t_sum_item        r_s0_item;
    logic                      w_div_ready;
    logic                      w_div_valid;
    lem_pkg::t_div_item        w_div_item;
    logic                      w_log_ready;
    logic                      w_log_valid;
    lem_pkg::t_lvl_item        w_log_item;
    logic                      w_out_ld;
    logic                      r_out_valid;
    logic [lem_pkg::LEVEL_W-1:0] r_level;
    logic [SW-1:0]             r_slot;

    assign w_group_eff = (r_group_size == '0) ? GW'(1) : r_group_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= lem_pkg::GROUP_RESET;
        end else if (i_cfg_we) begin
            r_group_size <= i_cfg_data;
        end
    end

    assign o_sample_ready = !r_s0_valid || w_div_ready;
    assign w_accept       = i_sample_valid && o_sample_ready;

    always_comb begin
        w_square       = i_sample * i_sample;
        n_square_sum   = r_square_sum + lem_pkg::SUM_W'($unsigned(w_square));
        n_sample_count = r_sample_count + 1'b1;
        w_group_done   = (n_sample_count >= w_group_eff);
        w_ring_inc     = {1'b0, r_ring_pos} + 1'b1;
        // wrap at the ring depth; beyond 512 the 9-bit slot wraps on its own
        n_ring_pos     = ({{(32 - SW - 1){1'b0}}, w_ring_inc} == 32'(RING_DEPTH))
                         ? '0 : w_ring_inc[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square_sum   <= '0;
            r_sample_count <= '0;
            r_ring_pos     <= '0;
        end else if (w_accept) begin
            if (w_group_done) begin
                r_square_sum   <= '0;
                r_sample_count <= '0;
                r_ring_pos     <= n_ring_pos;
            end else begin
                r_square_sum   <= n_square_sum;
                r_sample_count <= n_sample_count;
            end
        end
    end

    // hand the closed group to the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (o_sample_ready) begin
            r_s0_valid <= w_accept && w_group_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_group_done) begin
            r_s0_item.sum  <= n_square_sum;
            r_s0_item.slot <= r_ring_pos;
        end
    end

    lem_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s0_valid),
        .o_ready   (w_div_ready),
        .i_item    (r_s0_item),
        .i_divisor (w_group_eff),
        .o_valid   (w_div_valid),
        .i_ready   (w_log_ready),
        .o_item    (w_div_item)
    );

    lem_log #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .o_ready (w_log_ready),
        .i_item  (w_div_item),
        .o_valid (w_log_valid),
        .i_ready (w_out_ld),
        .o_item  (w_log_item)
    );

    assign w_out_ld = !r_out_valid || i_level_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ld) begin
            r_out_valid <= w_log_valid;
        end
    end

    // drop to zero below the floor, saturate at full scale
    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            if (!w_log_item.pos) begin
                r_level <= '0;
            end else if (w_log_item.sat) begin
                r_level <= '1;
            end else begin
                r_level <= w_log_item.prod[lem_pkg::DIV31_SHIFT +: lem_pkg::LEVEL_W];
            end
            r_slot <= w_log_item.slot;
        end
    end

    assign o_level_valid = r_out_valid;
    assign o_level       = r_level;
    assign o_slot        = r_slot;

endmodule

[design/lem_chk.sv]
// ----------------------------------------------------------------------------
// lem_chk
// Port-level checks for the log energy meter, bound to the top level.
// ----------------------------------------------------------------------------
module lem_chk #(
    parameter int RING_DEPTH = lem_pkg::RING_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_level_valid,
    input  logic                                i_level_ready,
    input  logic [lem_pkg::LEVEL_W-1:0]         o_level,
    input  logic [lem_pkg::SLOT_W-1:0]          o_slot
);

    localparam int SW = lem_pkg::SLOT_W;

    logic [SW-1:0] r_exp_slot;
    logic [SW:0]   w_slot_inc;
    logic [SW-1:0] n_exp_slot;
    logic          w_out_take;

    assign w_out_take = o_level_valid && i_level_ready;
    assign w_slot_inc = {1'b0, o_slot} + 1'b1;
    assign n_exp_slot = ({{(32 - SW - 1){1'b0}}, w_slot_inc} == 32'(RING_DEPTH))
                        ? '0 : w_slot_inc[SW-1:0];

    // track the slot the next delivered level must carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_slot <= '0;
        end else if (w_out_take) begin
            r_exp_slot <= n_exp_slot;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_level_valid)
        else $error("level valid right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_level_valid && !i_level_ready |=> o_level_valid)
        else $error("level valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_level_valid && !i_level_ready |=> $stable(o_level) && $stable(o_slot))
        else $error("level payload changed while stalled");

    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_take |-> o_slot == r_exp_slot)
        else $error("ring slot out of sequence");

endmodule

bind log_energy_meter lem_chk #(
    .RING_DEPTH (RING_DEPTH)
) u_lem_chk (.*);

[test/tb_log_energy_meter.sv]
// ----------------------------------------------------------------------------
// tb_log_energy_meter
// Self-checking testbench for the log energy meter. A queue-fed driver sends
// audio samples in random bursts, a monitor predicts each group's level and
// ring slot and compares every level word in order. The receiver stalls on
// its own random pattern, with long hold-offs that back the pipeline up.
// ----------------------------------------------------------------------------
module tb_log_energy_meter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W     = lem_pkg::SAMPLE_W;
    localparam int GROUP_W      = lem_pkg::GROUP_W;
    localparam int SUM_W        = lem_pkg::SUM_W;
    localparam int LEVEL_W      = lem_pkg::LEVEL_W;
    localparam int SLOT_W       = lem_pkg::SLOT_W;
    localparam int MEAN_FRAC    = lem_pkg::MEAN_FRAC;
    localparam int MANT_BITS    = lem_pkg::MANT_BITS;
    localparam int METER_RING   = lem_pkg::RING_DEPTH_DEF;
    localparam int TABLE_BITS   = lem_pkg::LOG_TABLE_BITS_DEF;
    localparam int LATENCY_PAD  = 24;
    localparam int RUN_LIMIT_NS = 4_000_000;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [SLOT_W-1:0]  slot;
    } t_level_word;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_cfg_we       = 1'b0;
    logic [GROUP_W-1:0]         i_cfg_data     = '0;
    logic                       i_sample_valid = 1'b0;
    logic                       o_sample_ready;
    logic signed [SAMPLE_W-1:0] i_sample       = '0;
    logic                       o_level_valid;
    logic                       i_level_ready  = 1'b0;
    logic [LEVEL_W-1:0]         o_level;
    logic [SLOT_W-1:0]          o_slot;

    // stimulus and expectations
    logic signed [SAMPLE_W-1:0] sample_q[$];
    t_level_word                pending_levels[$];

    // predictor state
    logic [GROUP_W-1:0] grp_size;
    logic [SUM_W-1:0]   acc_sum;
    logic [GROUP_W-1:0] acc_count;
    logic [SLOT_W-1:0]  ring_pos;

    int mismatches    = 0;
    int samples_taken = 0;
    int levels_seen   = 0;
    int zero_levels   = 0;
    int stall_cycles  = 0;
    bit tx_fire       = 1'b0;

    log_energy_meter #(
        .RING_DEPTH    (METER_RING),
        .LOG_TABLE_BITS(TABLE_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_sample_valid(i_sample_valid),
        .o_sample_ready(o_sample_ready),
        .i_sample      (i_sample),
        .o_level_valid (o_level_valid),
        .i_level_ready (i_level_ready),
        .o_level       (o_level),
        .o_slot        (o_slot)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // log2(1 + idx/2^TABLE_BITS) in Q16, squaring a Q30 value sixteen times
    function automatic longint unsigned frac_point(longint unsigned idx);
        longint unsigned y;
        longint unsigned acc;
        int              b;
        if (idx >= (64'd1 << TABLE_BITS)) begin
            return 64'd65536;
        end
        acc = 0;
        y   = (64'd1 << MANT_BITS) + (idx << (MANT_BITS - TABLE_BITS));
        for (b = 0; b < 16; b++) begin
            y   = (y * y) >> MANT_BITS;
            acc = acc << 1;
            if (y >= (64'd2 << MANT_BITS)) begin
                acc = acc | 64'd1;
                y   = y >> 1;
            end
        end
        return acc;
    endfunction

    // log2 of a nonzero value in Q16: leading-one position plus interpolated fraction
    function automatic longint unsigned log2_q16(longint unsigned v);
        int              p;
        longint unsigned m;
        longint unsigned idx;
        longint unsigned rem;
        longint unsigned e0;
        longint unsigned e1;
        p = 0;
        while (p < 63 && (v >> (p + 1)) != 0) begin
            p++;
        end
        m = v - (64'd1 << p);
        if (p >= MANT_BITS) begin
            m = m >> (p - MANT_BITS);
        end else begin
            m = m << (MANT_BITS - p);
        end
        idx = m >> (MANT_BITS - TABLE_BITS);
        rem = m & ((64'd1 << (MANT_BITS - TABLE_BITS)) - 1);
        e0  = frac_point(idx);
        e1  = frac_point(idx + 1);
        return (longint'(p) << 16) + e0 + (((e1 - e0) * rem) >> (MANT_BITS - TABLE_BITS));
    endfunction

    // add one sample into the group; return 1 with the level word when the group closes
    function automatic bit meter_take(logic signed [SAMPLE_W-1:0] s, output t_level_word w);
        longint          sq;
        longint unsigned g;
        longint unsigned mean;
        longint          l;
        longint          num;
        longint          lvl;
        w         = '0;
        sq        = longint'(s) * longint'(s);
        acc_sum   = acc_sum + SUM_W'(sq);
        acc_count = acc_count + 1'b1;
        g         = (grp_size == 0) ? 64'd1 : 64'(grp_size);
        if (64'(acc_count) < g) begin
            return 1'b0;
        end
        mean = (64'(acc_sum) << MEAN_FRAC) / g;
        lvl  = 0;
        if (mean != 0) begin
            l   = longint'(log2_q16(mean)) - (longint'(MEAN_FRAC) << 16);
            num = 5 * l - 64'sd31 * 65536;
            if (num > 0) begin
                lvl = num / 124;
                if (lvl > 65535) begin
                    lvl = 65535;
                end
            end
        end
        w.level   = LEVEL_W'(lvl);
        w.slot    = ring_pos;
        ring_pos  = SLOT_W'((int'(ring_pos) + 1) % METER_RING);
        acc_sum   = '0;
        acc_count = '0;
        return 1'b1;
    endfunction

    // driver: bursts of words with random gaps, hold each word until taken
    always @(posedge i_clk) begin
        tx_fire <= i_sample_valid && o_sample_ready;
    end

    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_sample_valid <= 1'b0;
        end else if (i_sample_valid && !tx_fire) begin
            // hold the offered word
        end else if (gap_left > 0) begin
            gap_left--;
            i_sample_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
            i_sample_valid <= 1'b1;
            i_sample       <= sample_q.pop_front();
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0:       gap_left = 0;
                    1:       gap_left = $urandom_range(1, 3);
                    2:       gap_left = $urandom_range(4, 20);
                    default: gap_left = $urandom_range(0, 1);
                endcase
            end else begin
                burst_left--;
            end
        end else begin
            i_sample_valid <= 1'b0;
        end
    end

    // receiver: stall pattern re-picked each time rx_phase wraps, plus two long hold-offs
    int  rx_mode      = 0;
    int  rx_phase     = 0;
    int  hold_left    = 0;
    bit  hold_a_done  = 1'b0;
    bit  hold_b_done  = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_level_ready <= 1'b0;
        end else begin
            if (!hold_a_done && levels_seen >= 50) begin
                hold_a_done = 1'b1;
                hold_left   = 300;
            end else if (!hold_b_done && levels_seen >= 500) begin
                hold_b_done = 1'b1;
                hold_left   = 250;
            end
            rx_phase++;
            if (rx_phase >= 50) begin
                rx_phase = 0;
                rx_mode  = $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_level_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       i_level_ready <= 1'b1;
                    1:       i_level_ready <= 1'($urandom_range(0, 1));
                    2:       i_level_ready <= ($urandom_range(0, 5) == 0);
                    default: i_level_ready <= rx_phase[2];
                endcase
            end
        end
    end

    // monitor: check level words in order, then predict from accepted samples
    always @(posedge i_clk) begin : mon
        t_level_word want;
        if (!i_rst_n) begin
            grp_size  = lem_pkg::GROUP_RESET;
            acc_sum   = '0;
            acc_count = '0;
            ring_pos  = '0;
        end else begin
            if (o_level_valid && i_level_ready) begin
                levels_seen++;
                if (pending_levels.size() == 0) begin
                    report_mismatch("level word with none expected, level", o_level, 0);
                end else begin
                    want = pending_levels.pop_front();
                    if (o_level !== want.level) begin
                        report_mismatch("level", o_level, want.level);
                    end
                    if (o_slot !== want.slot) begin
                        report_mismatch("slot", o_slot, want.slot);
                    end
                end
            end
            if (i_sample_valid && !o_sample_ready) begin
                stall_cycles++;
            end
            if (i_sample_valid && o_sample_ready) begin
                samples_taken++;
                if (meter_take(i_sample, want)) begin
                    if (want.level == 0) begin
                        zero_levels++;
                    end
                    pending_levels.push_back(want);
                end
            end
            if (i_cfg_we) begin
                grp_size = i_cfg_data;
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic signed [SAMPLE_W-1:0] r;
        r = SAMPLE_W'($urandom);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3:    return SAMPLE_W'(int'($urandom_range(0, 30)) - 15);
            4, 5, 6: return r;
            default: return r >>> $urandom_range(0, 15);
        endcase
    endfunction

    // wait until every word is sent and every level has come back, then let the pipe settle
    task automatic drain_levels();
        while (sample_q.size() != 0 || i_sample_valid || pending_levels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic write_group(logic [GROUP_W-1:0] g);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= g;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_phase(logic [GROUP_W-1:0] g, int count);
        int k;
        write_group(g);
        for (k = 0; k < count; k++) begin
            sample_q.push_back(random_sample());
        end
        drain_levels();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one word per level: extremes, silence and the noise-floor edge
        write_group(10'd1);
        sample_q.push_back(16'sd0);
        sample_q.push_back(16'sd1);
        sample_q.push_back(-16'sd1);
        sample_q.push_back(16'sh7FFF);
        sample_q.push_back(16'sh8000);
        sample_q.push_back(16'sd8);
        sample_q.push_back(16'sd9);
        sample_q.push_back(16'sd100);
        sample_q.push_back(16'sh5555);
        sample_q.push_back(16'shAAAA);
        drain_levels();

        // group size zero acts as one
        write_group(10'd0);
        sample_q.push_back(16'sh8000);
        sample_q.push_back(16'sd0);
        sample_q.push_back(16'sd12345);
        drain_levels();

        // shrink the group below the partial count: next word closes it
        write_group(10'd4);
        sample_q.push_back(16'sh7FFF);
        sample_q.push_back(-16'sd300);
        sample_q.push_back(16'sd77);
        drain_levels();
        write_group(10'd2);
        sample_q.push_back(16'sd5000);
        drain_levels();

        random_phase(10'd40, 80);
        random_phase(10'd1, 520);
        random_phase(10'd2, 80);
        random_phase(10'd3, 60);
        random_phase(10'd7, 70);
        random_phase(10'd255, 255);
        random_phase(10'd0, 60);
        random_phase(10'd5, 50);
        random_phase(10'd1, 30);

        $display("Run covered %0d samples and %0d levels, group sizes 0 to 255,",
                 samples_taken, levels_seen);
        $display("ring wrapped %0d times, %0d zero levels, %0d input stall cycles.",
                 levels_seen / METER_RING, zero_levels, stall_cycles);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS * 1ns);
        $display("Timeout with %0d levels still expected", pending_levels.size());
        $display("Verification failed");
        $finish;
    end

endmodule

[log_energy_meter.f]
design/lem_pkg.sv
design/lem_div.sv
design/lem_log.sv
design/log_energy_meter.sv
design/lem_chk.sv
test/tb_log_energy_meter.sv
